>>> src/bmd_pkg.sv
package bmd_pkg;

  // Fixed-point format and field widths.
  localparam int FractionBits = 8;
  localparam int PulseWidth   = 8;
  localparam int DriveLimit   = 255;

  // The serial multiplier walks a 9-bit multiplier one bit per cycle.
  localparam int MulW    = 9;
  localparam int MulCntW = $clog2(MulW + 1);

  // The widest product sum is prop_gain * (filtered << F) + integ_gain * integral,
  // which stays below 2^48. Two guard bits on top.
  localparam int AccW = 32 + FractionBits + MulW + 1;

  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PROP_GAIN     = 4'd0,
    CFG_INTEG_GAIN    = 4'd1,
    CFG_FILTER_KEEP   = 4'd2,
    CFG_FILTER_TAKE   = 4'd3,
    CFG_PULSE_SCALE   = 4'd4,
    CFG_INTEG_FLOOR   = 4'd5,
    CFG_INTEG_CEILING = 4'd6,
    CFG_UPDATE_PERIOD = 4'd7
  } cfg_idx_e;

  localparam logic [7:0]         PropGainRst     = 8'd10;
  localparam logic [7:0]         IntegGainRst    = 8'd67;
  localparam logic [8:0]         FilterKeepRst   = 9'd179;
  localparam logic [8:0]         FilterTakeRst   = 9'd77;
  localparam logic [8:0]         PulseScaleRst   = 9'd128;
  localparam logic signed [15:0] IntegFloorRst   = -16'sd3000;
  localparam logic [14:0]        IntegCeilingRst = 15'd3000;
  localparam logic [7:0]         UpdatePeriodRst = 8'd10;

  typedef struct packed {
    logic [7:0]         prop_gain;
    logic [7:0]         integ_gain;
    logic [8:0]         filter_keep;
    logic [8:0]         filter_take;
    logic [8:0]         pulse_scale;
    logic signed [15:0] integ_floor;
    logic [14:0]        integ_ceiling;
    logic [7:0]         update_period;
  } cfg_regs_t;

  typedef struct packed {
    logic [PulseWidth-1:0] left_pulses;
    logic [PulseWidth-1:0] right_pulses;
    logic signed [15:0]    balance_drive;
  } tick_t;

  typedef struct packed {
    logic               motor_reverse;
    logic [7:0]         motor_duty;
    logic signed [15:0] speed_command;
    logic               speed_updated;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACCUM,
    S_MUL_SPEED,
    S_MUL_TAKE,
    S_MUL_KEEP,
    S_INTEG,
    S_MUL_PROP,
    S_MUL_INTEG,
    S_DRIVE
  } state_e;

endpackage

>>> src/bmd_req_if.sv
interface bmd_req_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/bmd_cfg_regs.sv
module bmd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [bmd_pkg::CfgIdxW-1:0]   index_i,
  input  logic [bmd_pkg::CfgDataW-1:0]  data_i,
  output bmd_pkg::cfg_regs_t            cfg_o
);

  bmd_pkg::cfg_regs_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (bmd_pkg::cfg_idx_e'(index_i))
        bmd_pkg::CFG_PROP_GAIN:     cfg_d.prop_gain     = data_i[7:0];
        bmd_pkg::CFG_INTEG_GAIN:    cfg_d.integ_gain    = data_i[7:0];
        bmd_pkg::CFG_FILTER_KEEP:   cfg_d.filter_keep   = data_i[8:0];
        bmd_pkg::CFG_FILTER_TAKE:   cfg_d.filter_take   = data_i[8:0];
        bmd_pkg::CFG_PULSE_SCALE:   cfg_d.pulse_scale   = data_i[8:0];
        bmd_pkg::CFG_INTEG_FLOOR:   cfg_d.integ_floor   = data_i[15:0];
        bmd_pkg::CFG_INTEG_CEILING: cfg_d.integ_ceiling = data_i[14:0];
        bmd_pkg::CFG_UPDATE_PERIOD: cfg_d.update_period = data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain     <= bmd_pkg::PropGainRst;
      cfg_q.integ_gain    <= bmd_pkg::IntegGainRst;
      cfg_q.filter_keep   <= bmd_pkg::FilterKeepRst;
      cfg_q.filter_take   <= bmd_pkg::FilterTakeRst;
      cfg_q.pulse_scale   <= bmd_pkg::PulseScaleRst;
      cfg_q.integ_floor   <= bmd_pkg::IntegFloorRst;
      cfg_q.integ_ceiling <= bmd_pkg::IntegCeilingRst;
      cfg_q.update_period <= bmd_pkg::UpdatePeriodRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/bmd_serial_mac.sv
// Bit-serial multiply-accumulate: one multiplier bit per cycle, LSB first.
module bmd_serial_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bmd_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [bmd_pkg::AccW-1:0]    mcand_i,
  input  logic [bmd_pkg::MulW-1:0]           mult_i,
  output logic                               busy_o,
  output logic signed [bmd_pkg::AccW-1:0]    acc_o
);

  logic signed [bmd_pkg::AccW-1:0] acc_q, acc_d;
  logic signed [bmd_pkg::AccW-1:0] mcand_q, mcand_d;
  logic [bmd_pkg::MulW-1:0]        mult_q, mult_d;
  logic [bmd_pkg::MulCntW-1:0]     cnt_q, cnt_d;

  assign busy_o = (cnt_q != '0);
  assign acc_o  = acc_q;

  always_comb begin
    acc_d   = acc_q;
    mcand_d = mcand_q;
    mult_d  = mult_q;
    cnt_d   = cnt_q;
    if (ctrl_i.start) begin
      mcand_d = mcand_i;
      mult_d  = mult_i;
      cnt_d   = bmd_pkg::MulCntW'(bmd_pkg::MulW);
      acc_d   = ctrl_i.clear ? '0 : acc_q;
    end else if (busy_o) begin
      acc_d   = mult_q[0] ? acc_q + mcand_q : acc_q;
      mcand_d = mcand_q <<< 1;
      mult_d  = mult_q >> 1;
      cnt_d   = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    mult_q  <= mult_d;
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bmd_pkg::MulCntW'(bmd_pkg::MulW))
    else $error("serial MAC step count out of range");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |=> busy_o)
    else $error("serial MAC did not start after a start request");

endmodule

>>> src/balance_speed_pi_motor_drive_core.sv
// Balance and speed PI motor drive core.
//
// tick_i carries one control tick per request: left and right encoder pulse
// counts and the balance loop's signed output. drive_o returns exactly one
// request per tick with motor direction, duty, the current speed command and
// a flag that marks ticks on which the speed loop recomputed. cfg_i writes
// the eight tuning registers by index; it is always ready, and writes must
// only be made while no tick is in flight.
//
// A tick without a speed update passes from acceptance through the
// accumulate and drive states back to idle, where the next tick can be
// accepted; its result is registered in the drive state. A tick that runs
// the speed loop also passes through five multiplications on one bit-serial
// multiply-accumulate unit, the integral clamp and the drive stage.
//
// Reset clears the tick counter, the pulse sums, the filter, the integral,
// the speed command and the remembered direction, and loads the registers
// with their default tuning. The result sits in an output register: a new
// tick is accepted while it waits, but that tick's result is held back
// until the receiver has taken the previous one.
module balance_speed_pi_motor_drive_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  bmd_req_if.sink   tick_i,
  bmd_req_if.source drive_o,
  bmd_req_if.sink   cfg_i
);

  localparam int AccW = bmd_pkg::AccW;
  localparam int Frac = bmd_pkg::FractionBits;
  localparam int PW   = bmd_pkg::PulseWidth;
  localparam logic signed [16:0] DrvMax = 17'(bmd_pkg::DriveLimit);
  localparam logic signed [16:0] DrvMin = -17'(bmd_pkg::DriveLimit);

  // Configuration registers.
  bmd_pkg::cfg_regs_t cfg;
  bmd_pkg::cfg_wr_t   cfg_wr;

  assign cfg_wr      = cfg_i.payload;
  assign cfg_i.ready = 1'b1;

  bmd_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_i.valid),
    .index_i (cfg_wr.index),
    .data_i  (cfg_wr.data),
    .cfg_o   (cfg)
  );

  // Shared serial multiplier.
  bmd_pkg::mac_ctrl_t       mac_ctrl;
  logic signed [AccW-1:0]   mac_mcand;
  logic [bmd_pkg::MulW-1:0] mac_mult;
  logic                     mac_busy;
  logic signed [AccW-1:0]   mac_acc;

  bmd_serial_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .mcand_i (mac_mcand),
    .mult_i  (mac_mult),
    .busy_o  (mac_busy),
    .acc_o   (mac_acc)
  );

  // Saturating pulse accumulation; the 17-bit result is exact before clamping.
  function automatic logic signed [15:0] acc_pulses(logic signed [15:0] s,
                                                    logic [PW-1:0] p,
                                                    logic rev);
    logic [16:0] sx;
    logic [16:0] px;
    logic [16:0] t;
    sx = {s[15], s};
    px = 17'(p);
    t  = rev ? sx - px : sx + px;
    if (t[16] != t[15]) begin
      acc_pulses = t[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      acc_pulses = t[15:0];
    end
  endfunction

  bmd_pkg::state_e state_q, state_d;
  bmd_pkg::tick_t  tick_in;
  bmd_pkg::result_t out_q, out_d;

  logic [PW-1:0]      lp_q, rp_q;
  logic signed [15:0] bal_q;
  logic [7:0]         tick_q, tick_d;
  logic signed [15:0] lsum_q, lsum_d, rsum_q, rsum_d;
  logic signed [31:0] filt_q, filt_d;
  logic signed [23:0] integ_q, integ_d;
  logic signed [15:0] spd_q, spd_d;
  logic               last_rev_q, last_rev_d;
  logic               upd_q, upd_d;
  logic               out_valid_q, out_valid_d;
  logic               in_take;
  logic               out_load;

  assign tick_in      = tick_i.payload;
  assign in_take      = tick_i.valid && tick_i.ready;
  assign tick_i.ready = (state_q == bmd_pkg::S_IDLE);
  assign drive_o.valid   = out_valid_q;
  assign drive_o.payload = out_q;

  // Tick counter and pulse sums after this tick.
  logic [7:0]         tick_nx;
  logic signed [15:0] lsum_nx, rsum_nx;
  logic [16:0]        pulse_sum;
  logic               run_loop;

  assign tick_nx   = tick_q + 8'd1;
  assign run_loop  = (tick_nx > cfg.update_period);
  assign lsum_nx   = acc_pulses(lsum_q, lp_q, last_rev_q);
  assign rsum_nx   = acc_pulses(rsum_q, rp_q, last_rev_q);
  assign pulse_sum = {lsum_nx[15], lsum_nx} + {rsum_nx[15], rsum_nx};

  // Low-pass result: divide by 2^F toward zero, saturate to 32 bits.
  localparam int Q8W = AccW - Frac;
  logic [AccW-1:0]        rnd8;
  logic [Q8W-1:0]         q8;
  logic signed [31:0]     filt_new;

  assign rnd8 = mac_acc + (mac_acc[AccW-1] ? AccW'((1 << Frac) - 1) : '0);
  assign q8   = rnd8[AccW-1:Frac];

  always_comb begin
    if ((&q8[Q8W-1:31]) || !(|q8[Q8W-1:31])) begin
      filt_new = q8[31:0];
    end else begin
      filt_new = q8[Q8W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  // Speed command: negate, divide by 2^(2F) toward zero, saturate to 16 bits.
  localparam int Q16W = AccW - 2 * Frac;
  logic [AccW-1:0] rnd16;
  logic [Q16W:0]   nq16;
  logic signed [15:0] spd_new;

  assign rnd16 = mac_acc + (mac_acc[AccW-1] ? AccW'((1 << (2 * Frac)) - 1) : '0);
  assign nq16  = -{rnd16[AccW-1], rnd16[AccW-1:2*Frac]};

  always_comb begin
    if ((&nq16[Q16W:15]) || !(|nq16[Q16W:15])) begin
      spd_new = nq16[15:0];
    end else begin
      spd_new = nq16[Q16W] ? 16'sh8000 : 16'sh7fff;
    end
  end

  // Integral clamp. The floor is tested first so crossed bounds still give
  // one of the two bounds.
  logic signed [32:0] isum, integ_lo, integ_hi, integ_sx;

  assign isum     = {{9{integ_q[23]}}, integ_q} + {filt_q[31], filt_q};
  assign integ_lo = {{9{cfg.integ_floor[15]}}, cfg.integ_floor, {Frac{1'b0}}};
  assign integ_hi = {10'b0, cfg.integ_ceiling, {Frac{1'b0}}};
  assign integ_sx = {{9{integ_q[23]}}, integ_q};

  // Drive: balance minus speed command, clamped to the drive limit.
  logic signed [16:0] drv_diff;
  logic signed [8:0]  drv;
  logic [8:0]         drv_mag;

  assign drv_diff = {bal_q[15], bal_q} - {spd_q[15], spd_q};

  always_comb begin
    if (drv_diff > DrvMax) begin
      drv = 9'(DrvMax);
    end else if (drv_diff < DrvMin) begin
      drv = 9'(DrvMin);
    end else begin
      drv = drv_diff[8:0];
    end
    drv_mag = drv[8] ? -drv : drv;
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    lsum_d      = lsum_q;
    rsum_d      = rsum_q;
    filt_d      = filt_q;
    integ_d     = integ_q;
    spd_d       = spd_q;
    last_rev_d  = last_rev_q;
    upd_d       = upd_q;
    out_d       = out_q;
    out_load    = 1'b0;
    mac_ctrl    = '0;
    mac_mcand   = '0;
    mac_mult    = '0;

    unique case (state_q)
      bmd_pkg::S_IDLE: begin
        if (in_take) begin
          state_d = bmd_pkg::S_ACCUM;
        end
      end
      bmd_pkg::S_ACCUM: begin
        upd_d = run_loop;
        if (run_loop) begin
          tick_d         = '0;
          lsum_d         = '0;
          rsum_d         = '0;
          mac_ctrl.start = 1'b1;
          mac_ctrl.clear = 1'b1;
          mac_mcand      = {{(AccW-17){pulse_sum[16]}}, pulse_sum};
          mac_mult       = cfg.pulse_scale;
          state_d        = bmd_pkg::S_MUL_SPEED;
        end else begin
          tick_d  = tick_nx;
          lsum_d  = lsum_nx;
          rsum_d  = rsum_nx;
          state_d = bmd_pkg::S_DRIVE;
        end
      end
      bmd_pkg::S_MUL_SPEED: begin
        // The raw speed stays in the accumulator and becomes the next multiplicand.
        if (!mac_busy) begin
          mac_ctrl.start = 1'b1;
          mac_ctrl.clear = 1'b1;
          mac_mcand      = mac_acc;
          mac_mult       = cfg.filter_take;
          state_d        = bmd_pkg::S_MUL_TAKE;
        end
      end
      bmd_pkg::S_MUL_TAKE: begin
        if (!mac_busy) begin
          mac_ctrl.start = 1'b1;
          mac_ctrl.clear = 1'b0;
          mac_mcand      = {{(AccW-32){filt_q[31]}}, filt_q};
          mac_mult       = cfg.filter_keep;
          state_d        = bmd_pkg::S_MUL_KEEP;
        end
      end
      bmd_pkg::S_MUL_KEEP: begin
        if (!mac_busy) begin
          filt_d  = filt_new;
          state_d = bmd_pkg::S_INTEG;
        end
      end
      bmd_pkg::S_INTEG: begin
        if (isum < integ_lo) begin
          integ_d = integ_lo[23:0];
        end else if (isum > integ_hi) begin
          integ_d = integ_hi[23:0];
        end else begin
          integ_d = isum[23:0];
        end
        mac_ctrl.start = 1'b1;
        mac_ctrl.clear = 1'b1;
        mac_mcand      = {{(AccW-32-Frac){filt_q[31]}}, filt_q, {Frac{1'b0}}};
        mac_mult       = {1'b0, cfg.prop_gain};
        state_d        = bmd_pkg::S_MUL_PROP;
      end
      bmd_pkg::S_MUL_PROP: begin
        if (!mac_busy) begin
          mac_ctrl.start = 1'b1;
          mac_ctrl.clear = 1'b0;
          mac_mcand      = {{(AccW-24){integ_q[23]}}, integ_q};
          mac_mult       = {1'b0, cfg.integ_gain};
          state_d        = bmd_pkg::S_MUL_INTEG;
        end
      end
      bmd_pkg::S_MUL_INTEG: begin
        if (!mac_busy) begin
          spd_d   = spd_new;
          state_d = bmd_pkg::S_DRIVE;
        end
      end
      bmd_pkg::S_DRIVE: begin
        if (!out_valid_q || drive_o.ready) begin
          out_load            = 1'b1;
          out_d.motor_reverse = drv[8];
          out_d.motor_duty    = drv_mag[7:0];
          out_d.speed_command = spd_q;
          out_d.speed_updated = upd_q;
          last_rev_d          = drv[8];
          state_d             = bmd_pkg::S_IDLE;
        end
      end
      default: state_d = bmd_pkg::S_IDLE;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !drive_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmd_pkg::S_IDLE;
      tick_q      <= '0;
      lsum_q      <= '0;
      rsum_q      <= '0;
      filt_q      <= '0;
      integ_q     <= '0;
      spd_q       <= '0;
      last_rev_q  <= 1'b0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      lsum_q      <= lsum_d;
      rsum_q      <= rsum_d;
      filt_q      <= filt_d;
      integ_q     <= integ_d;
      spd_q       <= spd_d;
      last_rev_q  <= last_rev_d;
      upd_q       <= upd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_take) begin
      lp_q  <= tick_in.left_pulses;
      rp_q  <= tick_in.right_pulses;
      bal_q <= tick_in.balance_drive;
    end
  end

  a_mac_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctrl.start |-> !mac_busy)
    else $error("multiplier started while still busy");

  a_update_restarts_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmd_pkg::S_DRIVE && upd_q) |-> (tick_q == '0))
    else $error("speed update without tick counter restart");

  a_integ_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmd_pkg::S_MUL_PROP && $past(state_q) == bmd_pkg::S_INTEG &&
     integ_lo <= integ_hi) |-> (integ_sx >= integ_lo && integ_sx <= integ_hi))
    else $error("speed integral outside its bounds");

endmodule
